// ----- rtl/core/tcse_pkg.sv -----
package tcse_pkg;

    localparam int PC_W           = 16;
    localparam int WORD_W         = 20;
    localparam int BYTE_W         = 8;
    localparam int REG_W          = 32;
    localparam int RIDX_W         = 4;
    localparam int REG_N          = 16;
    localparam int KIND_W         = 2;
    localparam int PROG_DEPTH_DEF = 16384;
    localparam int DATA_DEPTH_DEF = 65536;

    typedef enum logic [KIND_W-1:0] {
        KIND_STEP = 2'd0,
        KIND_PROG = 2'd1,
        KIND_DATA = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_LDA  = 4'd2,
        OP_LDB  = 4'd3,
        OP_BEQ  = 4'd4,
        OP_JMP  = 4'd14,
        OP_HALT = 4'd15
    } t_op;

    typedef struct packed {
        logic              req;
        logic              we;
        logic [REG_W-1:0]  addr;
        logic [BYTE_W-1:0] wdata;
    } t_dm_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rdata;
    } t_dm_rsp;

endpackage

// ----- rtl/core/tcse_prog_mem.sv -----
module tcse_prog_mem #(
    parameter int PROG_DEPTH = tcse_pkg::PROG_DEPTH_DEF,
    parameter int PAW        = $clog2(PROG_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [PAW-1:0]              i_waddr,
    input  logic [tcse_pkg::WORD_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [PAW-1:0]              i_raddr,
    output logic [tcse_pkg::WORD_W-1:0] o_rdata
);
    import tcse_pkg::*;

    logic [WORD_W-1:0] r_mem [PROG_DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/tcse_data_mem.sv -----
module tcse_data_mem #(
    parameter int DATA_DEPTH = tcse_pkg::DATA_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcse_pkg::t_dm_req i_req,
    output tcse_pkg::t_dm_rsp o_rsp
);
    import tcse_pkg::*;

    localparam int DAW     = $clog2(DATA_DEPTH);
    localparam bit IS_POW2 = ((1 << DAW) == DATA_DEPTH);

    logic [BYTE_W-1:0] r_mem [DATA_DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic              r_done;
    logic              acc_en;
    logic              acc_we;
    logic [DAW-1:0]    acc_idx;
    logic [BYTE_W-1:0] acc_wdata;
    logic              busy;

    generate
        if (IS_POW2) begin : g_mask
            assign acc_en    = i_req.req;
            assign acc_we    = i_req.we;
            assign acc_idx   = i_req.addr[DAW-1:0];
            assign acc_wdata = i_req.wdata;
            assign busy      = 1'b0;
        end else begin : g_reduce
            // quotient estimate by reciprocal, at most one below the true quotient
            localparam int             QW       = REG_W + 1 - DAW;
            localparam logic [QW-1:0]  RECIP    = QW'((64'd1 << REG_W) / DATA_DEPTH);
            localparam logic [DAW:0]   DEPTH_LO = (DAW + 1)'(DATA_DEPTH);

            logic                 r_s1;
            logic                 r_s2;
            logic                 r_s3;
            logic                 r_we;
            logic [BYTE_W-1:0]    r_wdata;
            logic [REG_W-1:0]     r_x;
            logic [QW-1:0]        r_q;
            logic [DAW:0]         r_xlo;
            logic [DAW:0]         r_rem;
            logic [REG_W+QW-1:0]  prod;
            logic [QW-1:0]        n_q;
            logic [DAW:0]         qd_lo;
            logic [DAW:0]         n_rem;
            logic [DAW:0]         rem_sub;
            logic                 rem_ge;

            always_comb begin
                prod    = {{QW{1'b0}}, r_x} * {{REG_W{1'b0}}, RECIP};
                n_q     = prod[REG_W+QW-1:REG_W];
                qd_lo   = r_q[DAW:0] * DEPTH_LO;
                n_rem   = r_xlo - qd_lo;
                rem_sub = r_rem - DEPTH_LO;
                rem_ge  = r_rem >= DEPTH_LO;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_s1 <= 1'b0;
                    r_s2 <= 1'b0;
                    r_s3 <= 1'b0;
                end else begin
                    r_s1 <= i_req.req;
                    r_s2 <= r_s1;
                    r_s3 <= r_s2;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_req.req) begin
                    r_we    <= i_req.we;
                    r_wdata <= i_req.wdata;
                    r_x     <= i_req.addr;
                end
                if (r_s1) begin
                    r_q   <= n_q;
                    r_xlo <= r_x[DAW:0];
                end
                if (r_s2) begin
                    r_rem <= n_rem;
                end
            end

            assign acc_en    = r_s3;
            assign acc_we    = r_we;
            assign acc_idx   = rem_ge ? rem_sub[DAW-1:0] : r_rem[DAW-1:0];
            assign acc_wdata = r_wdata;
            assign busy      = r_s1 || r_s2 || r_s3;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (acc_en && acc_we) begin
            r_mem[acc_idx] <= acc_wdata;
        end
        if (acc_en && !acc_we) begin
            r_rdata <= r_mem[acc_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= acc_en && !acc_we;
        end
    end

    assign o_rsp.busy  = busy;
    assign o_rsp.done  = r_done;
    assign o_rsp.rdata = r_rdata;

endmodule

// ----- rtl/core/tcse_regfile.sv -----
module tcse_regfile (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_re,
    input  logic [tcse_pkg::RIDX_W-1:0] i_raddr_a,
    input  logic [tcse_pkg::RIDX_W-1:0] i_raddr_b,
    input  logic                        i_we,
    input  logic [tcse_pkg::RIDX_W-1:0] i_waddr,
    input  logic [tcse_pkg::REG_W-1:0]  i_wdata,
    output logic [tcse_pkg::REG_W-1:0]  o_rdata_a,
    output logic [tcse_pkg::REG_W-1:0]  o_rdata_b
);
    import tcse_pkg::*;

    logic [REG_W-1:0] r_mem [REG_N];
    logic [REG_N-1:0] r_valid;
    logic [REG_W-1:0] r_rdata_a;
    logic [REG_W-1:0] r_rdata_b;
    logic             r_va;
    logic             r_vb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_va <= r_valid[i_raddr_a];
                r_vb <= r_valid[i_raddr_b];
            end
        end
    end

    assign o_rdata_a = r_va ? r_rdata_a : '0;
    assign o_rdata_b = r_vb ? r_rdata_b : '0;

endmodule

// ----- rtl/core/toy_cpu_step_execute.sv -----
// Channel   Dir  Width            Content
// s_axis    in   tdata 48, user 2 store writes and step requests, one result each
// m_axis    out  tdata 56, user 1 pc, status and register write of each item
//
// Store writes and steps on a stopped core go back to back unless the output or the data store stalls.
// A step runs through fetch, register read and execute; a load adds the data
// store read, which for a DATA_DEPTH that is no power of two follows a
// three-stage address reduction that also holds a data write.
// Reset clears pc, halt and the register file; stores are not cleared.
// A stalled output holds the result and blocks the input until it transfers.
module toy_cpu_step_execute #(
    parameter int PROG_DEPTH = tcse_pkg::PROG_DEPTH_DEF,
    parameter int DATA_DEPTH = tcse_pkg::DATA_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // mem_address[15:0], program_word[35:16], data_byte[43:36], zero[47:44]
    input  logic [47:0] i_s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // program_counter[15:0], stopped[16], reg_write_index[20:17],
    // reg_write_value[52:21], zero[55:53]
    output logic [55:0] o_m_axis_tdata,
    // reg_write_valid[0]
    output logic [0:0]  o_m_axis_tuser
);
    import tcse_pkg::*;

    localparam int PAW = $clog2(PROG_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG,
        S_EXEC,
        S_LOAD,
        S_WB
    } t_state;

    t_state            r_state;
    logic [PC_W-1:0]   r_pc;
    logic              r_halt;
    logic              r_out_valid;
    logic [PC_W-1:0]   r_out_pc;
    logic              r_out_stopped;
    logic              r_out_wv;
    logic [RIDX_W-1:0] r_out_idx;
    logic [REG_W-1:0]  r_out_value;

    logic              in_acc;
    logic              out_free;
    logic              out_load;
    logic [KIND_W-1:0] kind;
    logic [PC_W-1:0]   in_addr;
    logic [WORD_W-1:0] in_word;
    logic [BYTE_W-1:0] in_byte;
    logic              stopped_now;
    logic              prog_in_range;

    logic [WORD_W-1:0] word;
    logic [3:0]        op;
    logic [RIDX_W-1:0] rd;
    logic [RIDX_W-1:0] rs;
    logic [RIDX_W-1:0] rt;
    logic [7:0]        imm;
    logic [REG_W-1:0]  ra;
    logic [REG_W-1:0]  rb;
    logic              is_load;
    logic              is_add;
    logic [PC_W-1:0]   pc_inc;
    logic [PC_W-1:0]   exec_pc;
    logic              exec_halt;
    logic              exec_fire;
    logic              load_done;

    t_dm_req           dm_req;
    t_dm_rsp           dm_rsp;
    logic              rf_we;
    logic [REG_W-1:0]  rf_wdata;

    assign kind    = i_s_axis_tuser;
    assign in_addr = i_s_axis_tdata[15:0];
    assign in_word = i_s_axis_tdata[35:16];
    assign in_byte = i_s_axis_tdata[43:36];

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && out_free && !dm_rsp.busy;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    assign stopped_now   = r_halt || ({1'b0, r_pc} >= (PC_W + 1)'(PROG_DEPTH));
    assign prog_in_range = {1'b0, in_addr} < (PC_W + 1)'(PROG_DEPTH);

    assign op  = word[19:16];
    assign rd  = word[15:12];
    assign rs  = word[11:8];
    assign rt  = word[7:4];
    assign imm = word[7:0];

    assign is_load = (op == OP_LDA) || (op == OP_LDB);
    assign is_add  = (op == OP_ADD);
    assign pc_inc  = r_pc + PC_W'(1);

    always_comb begin
        exec_pc   = pc_inc;
        exec_halt = r_halt;
        case (op)
            OP_BEQ: begin
                if (ra == rb) begin
                    exec_pc = {8'd0, imm};
                end
            end
            OP_JMP: begin
                exec_pc = word[15:0];
            end
            OP_HALT: begin
                exec_halt = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign exec_fire = (r_state == S_EXEC) && !is_load && out_free;
    assign load_done = (((r_state == S_LOAD) && dm_rsp.done) || (r_state == S_WB))
                       && out_free;
    assign out_load  = (in_acc && !((kind == KIND_STEP) && !stopped_now))
                       || exec_fire || load_done;

    tcse_prog_mem #(
        .PROG_DEPTH (PROG_DEPTH),
        .PAW        (PAW)
    ) u_prog_mem (
        .i_clk   (i_clk),
        .i_we    (in_acc && (kind == KIND_PROG) && prog_in_range),
        .i_waddr (in_addr[PAW-1:0]),
        .i_wdata (in_word),
        .i_re    (in_acc && (kind == KIND_STEP) && !stopped_now),
        .i_raddr (r_pc[PAW-1:0]),
        .o_rdata (word)
    );

    assign rf_we    = (exec_fire && is_add) || load_done;
    assign rf_wdata = load_done ? {24'd0, dm_rsp.rdata} : ra + rb;

    tcse_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_re      (r_state == S_REG),
        .i_raddr_a (rs),
        .i_raddr_b ((op == OP_BEQ) ? rd : rt),
        .i_we      (rf_we),
        .i_waddr   (rd),
        .i_wdata   (rf_wdata),
        .o_rdata_a (ra),
        .o_rdata_b (rb)
    );

    always_comb begin
        dm_req.req   = (in_acc && (kind == KIND_DATA)) || ((r_state == S_EXEC) && is_load);
        dm_req.we    = (r_state == S_IDLE);
        dm_req.addr  = (r_state == S_IDLE) ? {16'd0, in_addr} : ra + {24'd0, imm};
        dm_req.wdata = in_byte;
    end

    tcse_data_mem #(
        .DATA_DEPTH (DATA_DEPTH)
    ) u_data_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dm_req),
        .o_rsp   (dm_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if ((kind == KIND_STEP) && !stopped_now) begin
                            r_state <= S_REG;
                        end else begin
                            r_out_pc      <= r_pc;
                            r_out_stopped <= stopped_now;
                            r_out_wv      <= 1'b0;
                            r_out_idx     <= '0;
                            r_out_value   <= '0;
                        end
                    end
                end
                S_REG: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (is_load) begin
                        r_pc    <= pc_inc;
                        r_state <= S_LOAD;
                    end else if (out_free) begin
                        r_pc          <= exec_pc;
                        r_halt        <= exec_halt;
                        r_out_pc      <= exec_pc;
                        r_out_stopped <= exec_halt
                                         || ({1'b0, exec_pc} >= (PC_W + 1)'(PROG_DEPTH));
                        r_out_wv      <= is_add;
                        r_out_idx     <= is_add ? rd : '0;
                        r_out_value   <= is_add ? rf_wdata : '0;
                        r_state       <= S_IDLE;
                    end
                end
                S_LOAD, S_WB: begin
                    if (load_done) begin
                        r_out_pc      <= r_pc;
                        r_out_stopped <= stopped_now;
                        r_out_wv      <= 1'b1;
                        r_out_idx     <= rd;
                        r_out_value   <= rf_wdata;
                        r_state       <= S_IDLE;
                    end else if (dm_rsp.done) begin
                        r_state <= S_WB;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out_value, r_out_idx, r_out_stopped, r_out_pc};
    assign o_m_axis_tuser  = r_out_wv;

    a_step_fetch : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (kind == KIND_STEP) && !stopped_now |=> (r_state == S_REG))
        else $error("running step did not enter register read");

    a_pc_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EXEC) |=> (r_pc == $past(r_pc)))
        else $error("pc changed outside execute");

    a_halt_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

    a_load_mem_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |-> !dm_rsp.busy && !dm_req.req)
        else $error("data store active while load result waits");

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    import tcse_pkg::*;

    localparam int PROG_DEPTH  = PROG_DEPTH_DEF;
    localparam int DATA_DEPTH  = DATA_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1060;

    localparam logic [1:0] KIND_NOP = 2'd3;
    localparam logic [3:0] OP_NONE  = 4'd7;

    typedef struct packed {
        logic [15:0] pc;
        logic        stopped;
        logic        wr_valid;
        logic [3:0]  wr_idx;
        logic [31:0] wr_val;
    } t_core_status;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        tx_valid = 1'b0;
    logic [47:0] tx_data  = '0;
    logic [1:0]  tx_user  = '0;
    logic        rx_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [55:0] m_data;
    logic [0:0]  m_user;

    logic [15:0] cpu_pc     = '0;
    logic [31:0] cpu_regs [REG_N];
    logic        cpu_halted = 1'b0;
    logic [19:0] prog_mem  [PROG_DEPTH];
    bit          prog_seen [PROG_DEPTH];
    logic [7:0]  data_mem  [DATA_DEPTH];
    bit          data_seen [DATA_DEPTH];

    t_core_status due_status[$];
    int fail_count = 0;
    int items_sent = 0;
    int cycles     = 0;
    int tx_calm    = 0;
    int rx_calm    = 0;
    int rx_hold    = 0;

    toy_cpu_step_execute #(
        .PROG_DEPTH(PROG_DEPTH),
        .DATA_DEPTH(DATA_DEPTH)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (tx_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (tx_data),
        .i_s_axis_tuser  (tx_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (rx_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        for (int i = 0; i < REG_N; i++) cpu_regs[i] = '0;
    end

    function automatic int next_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 59) == 0) calm = $urandom_range(20, 80);
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit core_stopped();
        return cpu_halted || int'(cpu_pc) >= PROG_DEPTH;
    endfunction

    function automatic t_core_status cpu_apply(input logic [1:0] kind,
                                               input logic [15:0] addr,
                                               input logic [19:0] word,
                                               input logic [7:0] dbyte);
        t_core_status st;
        logic [19:0]  w;
        logic [3:0]   rd;
        logic [3:0]   rs;
        logic [31:0]  ea;
        st = '0;
        if (kind == KIND_PROG) begin
            if (int'(addr) < PROG_DEPTH) begin
                prog_mem[addr]  = word;
                prog_seen[addr] = 1'b1;
            end
        end else if (kind == KIND_DATA) begin
            data_mem[int'(addr) % DATA_DEPTH]  = dbyte;
            data_seen[int'(addr) % DATA_DEPTH] = 1'b1;
        end else if (kind == KIND_STEP && !core_stopped()) begin
            w  = prog_mem[cpu_pc];
            rd = w[15:12];
            rs = w[11:8];
            cpu_pc = cpu_pc + 16'd1;
            case (w[19:16])
                OP_ADD: begin
                    st.wr_valid = 1'b1;
                    st.wr_val   = cpu_regs[rs] + cpu_regs[w[7:4]];
                end
                OP_LDA, OP_LDB: begin
                    ea          = cpu_regs[rs] + 32'(w[7:0]);
                    st.wr_valid = 1'b1;
                    st.wr_val   = 32'(data_mem[ea % DATA_DEPTH]);
                end
                OP_BEQ: begin
                    if (cpu_regs[rd] == cpu_regs[rs]) cpu_pc = 16'(w[7:0]);
                end
                OP_JMP: cpu_pc = w[15:0];
                OP_HALT: cpu_halted = 1'b1;
                default: ;
            endcase
            if (st.wr_valid) begin
                st.wr_idx    = rd;
                cpu_regs[rd] = st.wr_val;
            end
        end
        st.pc      = cpu_pc;
        st.stopped = core_stopped();
        return st;
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [15:0] addr,
                             input logic [19:0] word, input logic [7:0] dbyte);
        int gap;
        gap = next_gap(tx_calm);
        if (gap > 0) begin
            tx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        due_status.push_back(cpu_apply(kind, addr, word, dbyte));
        tx_valid <= 1'b1;
        tx_data  <= {4'b0, dbyte, word, addr};
        tx_user  <= kind;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    function automatic logic [15:0] near_addr();
        if ($urandom_range(0, 6) != 0) return 16'($urandom_range(0, 255));
        return 16'($urandom_range(0, PROG_DEPTH - 2));
    endfunction

    // never halts and never jumps or branches out of the program store
    function automatic logic [19:0] random_instr();
        logic [19:0] w;
        int r;
        w = 20'($urandom);
        r = $urandom_range(0, 99);
        if (r < 30) begin
            w[19:16] = OP_ADD;
        end else if (r < 45) begin
            w[19:16] = OP_LDA;
        end else if (r < 58) begin
            w[19:16] = OP_LDB;
        end else if (r < 75) begin
            w[19:16] = OP_BEQ;
            if ($urandom_range(0, 2) == 0) w[11:8] = w[15:12];
        end else if (r < 85) begin
            w = {OP_JMP, near_addr()};
        end else begin
            while (w[19:16] == OP_ADD || w[19:16] == OP_LDA || w[19:16] == OP_LDB ||
                   w[19:16] == OP_BEQ || w[19:16] == OP_JMP || w[19:16] == OP_HALT)
                w[19:16] = 4'($urandom);
        end
        return w;
    endfunction

    // fill the fetched word and the load byte first when they were never written
    task automatic run_step();
        logic [19:0] w;
        logic [31:0] ea;
        if (!core_stopped()) begin
            if (!prog_seen[cpu_pc]) begin
                w = random_instr();
                if (int'(cpu_pc) == PROG_DEPTH - 1) w = {OP_JMP, near_addr()};
                send_item(KIND_PROG, cpu_pc, w, 8'($urandom));
            end
            w = prog_mem[cpu_pc];
            if (w[19:16] == OP_LDA || w[19:16] == OP_LDB) begin
                ea = (cpu_regs[w[11:8]] + 32'(w[7:0])) % DATA_DEPTH;
                if (!data_seen[ea])
                    send_item(KIND_DATA, ea[15:0], 20'($urandom), 8'($urandom));
            end
        end
        send_item(KIND_STEP, 16'($urandom), 20'($urandom), 8'($urandom));
    endtask

    task automatic random_noise();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send_item(KIND_PROG, near_addr(), random_instr(), 8'($urandom));
        else if (pick < 75)
            send_item(KIND_DATA, 16'($urandom), 20'($urandom), 8'($urandom));
        else if (pick < 90)
            send_item(KIND_PROG, 16'($urandom_range(PROG_DEPTH, 65535)), 20'($urandom),
                      8'($urandom));
        else
            send_item(KIND_NOP, 16'($urandom), 20'($urandom), 8'($urandom));
    endtask

    task automatic test_directed_ops();
        send_item(KIND_DATA, 16'h00FF, '1, 8'hFF);
        send_item(KIND_DATA, 16'h0205, '0, 8'h5A);
        send_item(KIND_DATA, 16'hFFFF, '1, 8'h00);
        send_item(KIND_PROG, 16'h0000, {OP_LDA, 4'd1, 4'd0, 8'hFF}, 8'h00);
        send_item(KIND_PROG, 16'h0001, {OP_ADD, 4'd2, 4'd1, 4'd1, 4'd0}, 8'hFF);
        send_item(KIND_PROG, 16'h0002, {OP_LDB, 4'd3, 4'd2, 8'h07}, 8'h00);
        send_item(KIND_PROG, 16'h0003, {OP_BEQ, 4'd0, 4'd4, 8'h06}, 8'hFF);
        send_item(KIND_PROG, 16'h0006, {OP_BEQ, 4'd1, 4'd2, 8'h00}, 8'h00);
        send_item(KIND_PROG, 16'h0007, {OP_NONE, 16'hFFFF}, 8'hFF);
        send_item(KIND_PROG, 16'h0008, {OP_JMP, 16'h0010}, 8'h00);
        send_item(KIND_PROG, 16'h0010, {OP_ADD, 4'd15, 4'd3, 4'd1, 4'd0}, 8'hFF);
        // drop: out of program store range
        send_item(KIND_PROG, 16'hFFFF, 20'hFFFFF, 8'hFF);
        send_item(KIND_PROG, 16'(PROG_DEPTH), 20'hFFFFF, 8'h00);
        send_item(KIND_NOP, 16'hFFFF, 20'hFFFFF, 8'hFF);
        repeat (8) send_item(KIND_STEP, 16'h0000, 20'h00000, 8'h00);
        send_item(KIND_NOP, 16'h0000, 20'h00000, 8'h00);
    endtask

    task automatic test_random_programs();
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 72) run_step();
            else random_noise();
        end
    endtask

    task automatic test_stop_and_after();
        int ending;
        logic [15:0] far;
        ending = $urandom_range(0, 2);
        if (ending == 0) begin
            send_item(KIND_PROG, cpu_pc, {OP_HALT, 16'($urandom)}, 8'($urandom));
            run_step();
        end else if (ending == 1) begin
            far = ($urandom_range(0, 1) == 0) ? 16'hFFFF
                                              : 16'($urandom_range(PROG_DEPTH, 65535));
            send_item(KIND_PROG, cpu_pc, {OP_JMP, far}, 8'($urandom));
            run_step();
        end else begin
            send_item(KIND_PROG, cpu_pc, {OP_JMP, 16'(PROG_DEPTH - 1)}, 8'($urandom));
            run_step();
            send_item(KIND_PROG, 16'(PROG_DEPTH - 1), {OP_ADD, 16'($urandom)}, 8'($urandom));
            run_step();
        end
        repeat (14) begin
            if ($urandom_range(0, 1) == 0) run_step();
            else random_noise();
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(negedge clk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            rx_ready <= 1'b0;
        end else begin
            rx_hold = next_gap(rx_calm);
            rx_ready <= (rx_hold == 0);
        end
    end

    always @(posedge clk) begin
        t_core_status got;
        t_core_status want;
        if (rst_n && m_valid && rx_ready) begin
            got.pc       = m_data[15:0];
            got.stopped  = m_data[16];
            got.wr_idx   = m_data[20:17];
            got.wr_val   = m_data[52:21];
            got.wr_valid = m_user[0];
            if (due_status.size() == 0) begin
                $display("%0t: unexpected transfer pc %h stopped %b write %b r%0d=%h",
                         $time, got.pc, got.stopped, got.wr_valid, got.wr_idx, got.wr_val);
                fail_count++;
            end else begin
                want = due_status.pop_front();
                check_field("program_counter", 32'(want.pc), 32'(got.pc));
                check_field("stopped", 32'(want.stopped), 32'(got.stopped));
                check_field("reg_write_valid", 32'(want.wr_valid), 32'(got.wr_valid));
                check_field("reg_write_index", 32'(want.wr_idx), 32'(got.wr_idx));
                check_field("reg_write_value", want.wr_val, got.wr_val);
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_ops();
        test_random_programs();
        test_stop_and_after();
        tx_valid <= 1'b0;
        while (due_status.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/tcse_pkg.sv
rtl/core/tcse_prog_mem.sv
rtl/core/tcse_data_mem.sv
rtl/core/tcse_regfile.sv
rtl/core/toy_cpu_step_execute.sv
tb/sv/tb.sv
